### hw/rtl/rtt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants of the repeating timer table
// Command and result transactions, the stored timer entry and the cell
// control group.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int SLOTS = 16;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_KILL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_KILL  = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] timer_id;
    logic [31:0] period_ticks;
    logic [31:0] repeat_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [31:0] fired_id;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] period;
    logic [31:0] repeats;
    logic [31:0] countdown;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### hw/rtl/rtt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtt_cell: one timer slot of the table
// Holds one entry; loads from the write port or takes its upper neighbor's
// entry when the row shifts toward slot 0.
// ----------------------------------------------------------------------------
module rtt_cell
  import rtt_pkg::*;
(
  input  wire        clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     load_entry,
  input  entry_t     upper_entry,
  output entry_t     entry
);

  // Load wins over shift: the write index lands after the shift.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      entry <= load_entry;
    end else if (ctrl.shift) begin
      entry <= upper_entry;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/repeating_timer_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// repeating_timer_table: ordered table of repeating software timers
// A row of timer cells swept through a single update head at slot 0.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. cmd carries opcode, timer_id, period_ticks, repeat_count.
//   Result channel: each result sits on result for one cycle with strobe
//   high; result.last marks the final result of a command. The receiver has
//   no way to stall, so every strobed result must be captured.
//   Set (and an unused opcode): one result in the cycle after the command;
//   busy stays low, so a new command may be issued back to back.
//   Kill: the row of N live entries rotates through the head, one entry per
//   cycle. Busy is high for the rotation and the kill status is strobed as
//   busy drops (for an empty table it arrives in the cycle after the
//   command, and busy stays low).
//   Tick: the same rotation emits one fired result in the cycle after each
//   firing entry passes the head, then the tick-done result from the
//   finish state after the rotation; busy stays high through that state
//   (done arrives in the cycle after the command if the table is empty).
//   Rate is set by the single update head: one entry per clock.
//   Reset (rst, synchronous) empties the table and drops any sweep in
//   flight; slot contents are left as they are and never read.
// ----------------------------------------------------------------------------
module repeating_timer_table
  import rtt_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    strobe,
  output result_t result
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;      // live entries in slots 0..count-1
  logic [CNT_W-1:0]  rem;        // entries still to pass the head
  logic [CNT_W-1:0]  kept;       // entries written back so far
  logic              sweep_tick; // sweep is a tick, else a kill
  logic [31:0]       kill_id;
  logic              any;

  entry_t            cells   [SLOTS];
  entry_t            uppers  [SLOTS];
  cell_ctrl_t        ctrls   [SLOTS];

  entry_t            head;
  entry_t            processed;
  entry_t            load_entry;
  logic              fire;
  logic              keep;
  logic              hit;
  logic              accept;
  logic              set_ok;
  logic              wr_en;
  logic [CNT_W-1:0]  wr_pos;
  logic [IDX_W-1:0]  wr_idx;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign head   = cells[0];
  assign set_ok = (cmd.period_ticks != 32'd0) && (count < CNT_W'(SLOTS));

  // Update head: decide fate of the entry leaving slot 0.
  always_comb begin
    processed = head;
    fire      = 1'b0;
    if (sweep_tick) begin
      fire = (head.countdown <= 32'd1);
      if (fire) begin
        processed.countdown = head.period;
        if (head.repeats == 32'd1) begin
          processed.repeats = 32'd0;
        end else if (head.repeats > 32'd1 && head.repeats != FOREVER) begin
          processed.repeats = head.repeats - 32'd1;
        end
      end else begin
        processed.countdown = head.countdown - 32'd1;
      end
      keep = (processed.repeats != 32'd0);
      hit  = fire;
    end else begin
      keep = (head.id != kill_id);
      hit  = !keep;
    end
  end

  // Write port: during a sweep, a kept entry lands right above the
  // unprocessed part and the earlier kept entries after the shift; a set appends at slot count.
  always_comb begin
    if (state == ST_SWEEP) begin
      wr_en      = keep;
      wr_pos     = rem - CNT_W'(1) + kept;
      load_entry = processed;
    end else begin
      wr_en      = accept && (cmd.opcode == OP_SET) && set_ok;
      wr_pos     = count;
      load_entry = '{id: cmd.timer_id, period: cmd.period_ticks,
                     repeats: cmd.repeat_count, countdown: cmd.period_ticks};
    end
    wr_idx = wr_pos[IDX_W-1:0];
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cells
    if (g == SLOTS - 1) begin : g_top
      assign uppers[g] = cells[g];
    end else begin : g_mid
      assign uppers[g] = cells[g+1];
    end
    assign ctrls[g].shift = (state == ST_SWEEP);
    assign ctrls[g].load  = wr_en && (wr_idx == IDX_W'(g));

    rtt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrls[g]),
      .load_entry  (load_entry),
      .upper_entry (uppers[g]),
      .entry       (cells[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd.opcode) inside
              OP_SET: begin
                strobe <= 1'b1;
                result <= '{kind: KIND_SET, ok: set_ok, fired_id: 32'd0, last: 1'b1};
                if (set_ok) begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_KILL, OP_TICK: begin
                if (count == '0) begin
                  // Empty table: answer at once.
                  strobe <= 1'b1;
                  result <= '{kind: (cmd.opcode == OP_TICK) ? KIND_DONE : KIND_KILL,
                              ok: 1'b0, fired_id: 32'd0, last: 1'b1};
                end else begin
                  state      <= ST_SWEEP;
                  rem        <= count;
                  kept       <= '0;
                  any        <= 1'b0;
                  sweep_tick <= (cmd.opcode == OP_TICK);
                  kill_id    <= cmd.timer_id;
                end
              end
              default: begin
                strobe <= 1'b1;
                result <= '{kind: KIND_SET, ok: 1'b0, fired_id: 32'd0, last: 1'b1};
              end
            endcase
          end
        end
        ST_SWEEP: begin
          rem  <= rem - CNT_W'(1);
          kept <= kept + CNT_W'(keep);
          any  <= any | hit;
          if (sweep_tick && fire) begin
            strobe <= 1'b1;
            result <= '{kind: KIND_FIRED, ok: 1'b1, fired_id: head.id, last: 1'b0};
          end
          if (rem == CNT_W'(1)) begin
            count <= kept + CNT_W'(keep);
            if (sweep_tick) begin
              state <= ST_FINISH;
            end else begin
              state  <= ST_IDLE;
              strobe <= 1'b1;
              result <= '{kind: KIND_KILL, ok: any | hit, fired_id: 32'd0, last: 1'b1};
            end
          end
        end
        ST_FINISH: begin
          state  <= ST_IDLE;
          strobe <= 1'b1;
          result <= '{kind: KIND_DONE, ok: any, fired_id: 32'd0, last: 1'b1};
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The table never holds more than SLOTS entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SLOTS))
    else $error("entry count exceeds table size");

  // Written-back entries never outrun the entries already processed.
  a_sweep_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (rem != '0) &&
      ({1'b0, kept} + {1'b0, rem} <= {1'b0, count}))
    else $error("sweep bookkeeping out of range");

  // A fired result is never the last of its command.
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.kind == KIND_FIRED) |-> (!result.last && result.ok))
    else $error("fired result flagged last");

  // A set command answers in the very next cycle.
  a_set_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_SET) |=>
      (strobe && result.kind == KIND_SET && result.last))
    else $error("set status missing");

endmodule
`default_nettype wire
